[rtl/hufd_pkg.sv]
// ----------------------------------------------------------------------------
// hufd_pkg
// Shared types and codes for the table-driven Huffman decoder.
// ----------------------------------------------------------------------------
`default_nettype none

package hufd_pkg;

    // Item function codes
    localparam logic [1:0] FUNC_LOAD   = 2'd0;
    localparam logic [1:0] FUNC_DECODE = 2'd1;
    localparam logic [1:0] FUNC_CLEAR  = 2'd2;

    // Fixed field widths
    localparam int SYM_W   = 8;
    localparam int CODE_W  = 32;
    localparam int LEN_W   = 6;
    localparam int IDX_W   = 8;
    localparam int COUNT_W = 9;

    // Input word
    typedef struct packed {
        logic [1:0]        func;
        logic [IDX_W-1:0]  entry_index;
        logic [SYM_W-1:0]  entry_symbol;
        logic [CODE_W-1:0] entry_code;
        logic [LEN_W-1:0]  entry_length;
        logic              code_bit;
    } in_word_t;

    // Result word
    typedef struct packed {
        logic [SYM_W-1:0] symbol;
        logic             overflow;
    } out_word_t;

    // One code table entry
    typedef struct packed {
        logic [SYM_W-1:0]  symbol;
        logic [CODE_W-1:0] code;
        logic [LEN_W-1:0]  length;
    } entry_t;

endpackage

`default_nettype wire

[rtl/hufd_table.sv]
// ----------------------------------------------------------------------------
// hufd_table
// Code table memory: one write port, one registered read port.
// ----------------------------------------------------------------------------
`default_nettype none

module hufd_table #(
    parameter int TABLE_DEPTH = 256
) (
    input  wire logic                           clk,
    input  wire logic                           wr_en,
    input  wire logic [$clog2(TABLE_DEPTH)-1:0] wr_addr,
    input  wire hufd_pkg::entry_t               wr_entry,
    input  wire logic                           rd_en,
    input  wire logic [$clog2(TABLE_DEPTH)-1:0] rd_addr,
    output hufd_pkg::entry_t                    rd_entry
);

    hufd_pkg::entry_t mem [TABLE_DEPTH];
    hufd_pkg::entry_t rd_entry_reg;

    // Write one entry
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_entry;
        end
    end

    // Registered read
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_entry_reg <= mem[rd_addr];
        end
    end

    assign rd_entry = rd_entry_reg;

endmodule

`default_nettype wire

[rtl/hufd_cmp.sv]
// ----------------------------------------------------------------------------
// hufd_cmp
// Shared compare unit: tests one table entry against the pending code.
// ----------------------------------------------------------------------------
`default_nettype none

module hufd_cmp #(
    parameter int MAX_CODE_LEN = 32
) (
    input  wire hufd_pkg::entry_t                     entry,
    input  wire logic [MAX_CODE_LEN-1:0]              pending_code,
    input  wire logic [$clog2(MAX_CODE_LEN+1)-1:0]    pending_len,
    output logic                                      hit
);

    localparam int PLW = $clog2(MAX_CODE_LEN + 1);
    localparam int XW  = (PLW > hufd_pkg::LEN_W) ? PLW : hufd_pkg::LEN_W;
    localparam int CW  = (MAX_CODE_LEN > hufd_pkg::CODE_W) ? MAX_CODE_LEN
                                                          : hufd_pkg::CODE_W;

    logic          len_eq;
    logic [CW-1:0] code_mask;
    logic [CW-1:0] code_ext;
    logic [CW-1:0] pend_ext;

    // Length must match and be nonzero
    assign len_eq = (XW'(entry.length) == XW'(pending_len)) &&
                    (entry.length != '0);

    // Keep only the low length bits of the stored code
    assign code_mask = ~({CW{1'b1}} << entry.length);
    assign code_ext  = CW'(entry.code) & code_mask;
    assign pend_ext  = CW'(pending_code);

    assign hit = len_eq && (code_ext == pend_ext);

endmodule

`default_nettype wire

[rtl/huffman_table_decoder.sv]
// Decode word: the bit joins the pending code, then the table scan reads one entry per cycle,
//   N = min(table_entries, TABLE_DEPTH) entries from slot zero; a match ends it via ST_FINISH.
// A new word is taken only in idle, after the scan and any result hand-off are done.
// Load and clear words: one per cycle while idle; an unknown func is dropped.
// Reset (rst_n low, asynchronous): pending code, table_entries and handshake
//   state clear; the code table memory is not cleared and holds junk until loaded.
// ----------------------------------------------------------------------------
// huffman_table_decoder
// Bit-serial Huffman decoder that scans a loaded code table per decoded bit.
// ----------------------------------------------------------------------------
`default_nettype none

module huffman_table_decoder #(
    parameter int TABLE_DEPTH  = 256,
    parameter int MAX_CODE_LEN = 32
) (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              cfg_wr_en,
    input  wire logic [hufd_pkg::COUNT_W-1:0]      cfg_wr_data,
    input  wire logic                              in_valid,
    output logic                                   in_ready,
    input  wire hufd_pkg::in_word_t                in_data,
    output logic                                   out_valid,
    input  wire logic                              out_ready,
    output hufd_pkg::out_word_t                    out_data
);

    localparam int AW  = $clog2(TABLE_DEPTH);
    localparam int CW  = $clog2(TABLE_DEPTH + 1);
    localparam int LW  = (CW > hufd_pkg::COUNT_W) ? CW : hufd_pkg::COUNT_W;
    localparam int IW  = (AW > hufd_pkg::IDX_W) ? AW : hufd_pkg::IDX_W;
    localparam int PLW = $clog2(MAX_CODE_LEN + 1);

    localparam logic [IW:0] IDX_LIMIT = (IW + 1)'(TABLE_DEPTH);

    localparam logic [1:0] ST_IDLE   = 2'd0;
    localparam logic [1:0] ST_SCAN   = 2'd1;
    localparam logic [1:0] ST_FINISH = 2'd2;

    logic [1:0]                       state_reg, state_next;
    logic [hufd_pkg::COUNT_W-1:0]     entries_reg;
    logic [MAX_CODE_LEN-1:0]          pend_code_reg, pend_code_next;
    logic [PLW-1:0]                   pend_len_reg, pend_len_next;
    logic [CW-1:0]                    scan_idx_reg, scan_idx_next;
    logic                             data_valid_reg, data_valid_next;
    hufd_pkg::out_word_t              res_reg, res_next;
    logic                             out_valid_reg, out_valid_next;
    hufd_pkg::out_word_t              out_data_reg, out_data_next;

    logic                             accept;
    logic [LW-1:0]                    limit;
    logic                             issue;
    logic                             hit;
    logic                             out_free;
    logic [IW-1:0]                    idx_ext;
    logic                             tbl_wr_en;
    hufd_pkg::entry_t                 wr_entry;
    hufd_pkg::entry_t                 rd_entry;

    assign accept   = in_valid && in_ready;
    assign in_ready = (state_reg == ST_IDLE);
    assign out_free = !out_valid_reg || out_ready;

    // Clamp the searched count to the table depth
    always_comb
    begin
        if (LW'(entries_reg) > LW'(TABLE_DEPTH))
        begin
            limit = LW'(TABLE_DEPTH);
        end
        else
        begin
            limit = LW'(entries_reg);
        end
    end

    assign issue = (state_reg == ST_SCAN) && (LW'(scan_idx_reg) < limit);

    // Table load path
    assign idx_ext   = IW'(in_data.entry_index);
    assign tbl_wr_en = accept && (in_data.func == hufd_pkg::FUNC_LOAD) &&
                       ({1'b0, idx_ext} < IDX_LIMIT);
    assign wr_entry.symbol = in_data.entry_symbol;
    assign wr_entry.code   = in_data.entry_code;
    assign wr_entry.length = in_data.entry_length;

    hufd_table #(
        .TABLE_DEPTH (TABLE_DEPTH)
    ) u_table (
        .clk      (clk),
        .wr_en    (tbl_wr_en),
        .wr_addr  (idx_ext[AW-1:0]),
        .wr_entry (wr_entry),
        .rd_en    (issue),
        .rd_addr  (scan_idx_reg[AW-1:0]),
        .rd_entry (rd_entry)
    );

    hufd_cmp #(
        .MAX_CODE_LEN (MAX_CODE_LEN)
    ) u_cmp (
        .entry        (rd_entry),
        .pending_code (pend_code_reg),
        .pending_len  (pend_len_reg),
        .hit          (hit)
    );

    // Sequencer
    always_comb
    begin
        state_next      = state_reg;
        pend_code_next  = pend_code_reg;
        pend_len_next   = pend_len_reg;
        scan_idx_next   = scan_idx_reg;
        data_valid_next = 1'b0;
        res_next        = res_reg;
        out_valid_next  = out_valid_reg && !out_ready;
        out_data_next   = out_data_reg;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    case (in_data.func)
                        hufd_pkg::FUNC_DECODE:
                        begin
                            // Shift the bit in and start the scan at entry zero
                            pend_code_next = {pend_code_reg[MAX_CODE_LEN-2:0],
                                              in_data.code_bit};
                            pend_len_next  = pend_len_reg + PLW'(1);
                            scan_idx_next  = '0;
                            state_next     = ST_SCAN;
                        end
                        hufd_pkg::FUNC_CLEAR:
                        begin
                            pend_code_next = '0;
                            pend_len_next  = '0;
                        end
                        default:
                        begin
                            pend_code_next = pend_code_reg;
                        end
                    endcase
                end
            end
            ST_SCAN:
            begin
                // Advance the read address; compare the entry read last cycle
                data_valid_next = issue;
                if (issue)
                begin
                    scan_idx_next = scan_idx_reg + CW'(1);
                end
                if (data_valid_reg && hit)
                begin
                    res_next.symbol   = rd_entry.symbol;
                    res_next.overflow = 1'b0;
                    data_valid_next   = 1'b0;
                    state_next        = ST_FINISH;
                end
                else if (!issue)
                begin
                    if (pend_len_reg >= PLW'(MAX_CODE_LEN))
                    begin
                        res_next.symbol   = '0;
                        res_next.overflow = 1'b1;
                        state_next        = ST_FINISH;
                    end
                    else
                    begin
                        state_next = ST_IDLE;
                    end
                end
            end
            ST_FINISH:
            begin
                // Hand the result to the output register and drop pending bits
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_data_next  = res_reg;
                    pend_code_next = '0;
                    pend_len_next  = '0;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            entries_reg    <= '0;
            pend_code_reg  <= '0;
            pend_len_reg   <= '0;
            scan_idx_reg   <= '0;
            data_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            pend_code_reg  <= pend_code_next;
            pend_len_reg   <= pend_len_next;
            scan_idx_reg   <= scan_idx_next;
            data_valid_reg <= data_valid_next;
            out_valid_reg  <= out_valid_next;
            if (cfg_wr_en)
            begin
                entries_reg <= cfg_wr_data;
            end
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        res_reg      <= res_next;
        out_data_reg <= out_data_next;
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    // Read data is only flagged valid right after a scan cycle
    a_valid_after_scan: assert property (@(posedge clk) disable iff (!rst_n)
        data_valid_reg |-> $past(state_reg) == ST_SCAN)
        else $error("table read flagged valid outside a scan");

    // Pending length never passes the maximum code length
    a_pend_len_bound: assert property (@(posedge clk) disable iff (!rst_n)
        pend_len_reg <= PLW'(MAX_CODE_LEN))
        else $error("pending length above maximum");

    // An overflow word carries a zero symbol
    a_ovf_symbol: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_data_reg.overflow) |-> out_data_reg.symbol == '0)
        else $error("overflow word with nonzero symbol");

    // Handing off a result clears the pending code and returns to idle
    a_finish_clear: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_FINISH && out_free) |=>
            (pend_len_reg == '0 && state_reg == ST_IDLE && out_valid_reg))
        else $error("result hand-off did not clear pending state");

    // Input is never taken while a decode is in flight
    a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_SCAN || state_reg == ST_FINISH) |-> !accept)
        else $error("word accepted during a decode");

endmodule

`default_nettype wire
